[rtl/core/kfr_pkg.sv]
// ----------------------------------------------------------------------------
// kfr_pkg
// Types, constants and CRC-16/MODBUS nibble-table functions for the key-panel
// frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kfr_pkg;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [7:0]  HDR_BYTE0   = 8'hA5;
  localparam logic [7:0]  HDR_BYTE1   = 8'h55;
  localparam logic [7:0]  FIXED_BYTE5 = 8'h55;
  localparam logic [3:0]  NIB_MASK    = 4'hF;

  localparam int unsigned COUNT_W = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd9;
  localparam logic [COUNT_W-1:0] FRAME_BYTES = 4'd8;
  localparam logic [COUNT_W-1:0] CRC_SPAN    = 4'd6;

  localparam logic [COUNT_W-1:0] POS_HDR0   = 4'd0;
  localparam logic [COUNT_W-1:0] POS_HDR1   = 4'd1;
  localparam logic [COUNT_W-1:0] POS_KEYLO  = 4'd2;
  localparam logic [COUNT_W-1:0] POS_KEYHI  = 4'd3;
  localparam logic [COUNT_W-1:0] POS_ID     = 4'd4;
  localparam logic [COUNT_W-1:0] POS_FIXED  = 4'd5;
  localparam logic [COUNT_W-1:0] POS_CRC_LO = 4'd6;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_HEADER = 2'd2,
    ERR_CRC    = 2'd3
  } err_t;

  function automatic logic [15:0] crc_nib_tab(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'h0: v = 16'h0000;
      4'h1: v = 16'hCC01;
      4'h2: v = 16'hD801;
      4'h3: v = 16'h1400;
      4'h4: v = 16'hF001;
      4'h5: v = 16'h3C00;
      4'h6: v = 16'h2800;
      4'h7: v = 16'hE401;
      4'h8: v = 16'hA001;
      4'h9: v = 16'h6C00;
      4'hA: v = 16'h7800;
      4'hB: v = 16'hB401;
      4'hC: v = 16'h5000;
      4'hD: v = 16'h9C01;
      4'hE: v = 16'h8801;
      4'hF: v = 16'h4400;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  // low nibble first, then high nibble
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] c1;
    logic [15:0] c2;
    c1 = crc_nib_tab((b[3:0] ^ c[3:0]) & NIB_MASK) ^ (c >> 4);
    c2 = crc_nib_tab((b[7:4] ^ c1[3:0]) & NIB_MASK) ^ (c1 >> 4);
    return c2;
  endfunction

endpackage

[rtl/core/key_frame_receiver_crc16_top.sv]
// ----------------------------------------------------------------------------
// key_frame_receiver_crc16_top
// out_valid is registered, rising in the cycle after the last byte is taken.
// Throughput: one byte per cycle while in_ready is high; CRC nibble steps
// and frame checks sit between the input handshake and the result register.
// Reset: synchronous, clears the frame state and drops out_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_frame_receiver_crc16_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       end_of_frame,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       frame_ok,
  output logic [1:0] error_code,
  output logic [9:0] pressed_keys,
  output logic [7:0] frame_number
);

  logic [kfr_pkg::COUNT_W-1:0] byte_count;
  logic [kfr_pkg::COUNT_W-1:0] byte_count_next;
  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  logic        header_good;
  logic        header_good_next;
  logic [7:0]  keys_low_byte;
  logic [7:0]  keys_low_byte_next;
  logic [1:0]  keys_high_bits;
  logic [1:0]  keys_high_bits_next;
  logic [7:0]  captured_id;
  logic [7:0]  captured_id_next;
  logic [7:0]  crc_low_received;
  logic [7:0]  crc_low_received_next;

  logic         accept;
  logic [15:0]  rx_crc;
  kfr_pkg::err_t err;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    running_crc_next      = running_crc;
    header_good_next      = header_good;
    keys_low_byte_next    = keys_low_byte;
    keys_high_bits_next   = keys_high_bits;
    captured_id_next      = captured_id;
    crc_low_received_next = crc_low_received;

    if (byte_count < kfr_pkg::CRC_SPAN) begin
      running_crc_next = kfr_pkg::crc_byte(running_crc, rx_byte);
    end

    case (byte_count)
      kfr_pkg::POS_HDR0: begin
        if (rx_byte != kfr_pkg::HDR_BYTE0) header_good_next = 1'b0;
      end
      kfr_pkg::POS_HDR1: begin
        if (rx_byte != kfr_pkg::HDR_BYTE1) header_good_next = 1'b0;
      end
      kfr_pkg::POS_KEYLO:  keys_low_byte_next    = rx_byte;
      kfr_pkg::POS_KEYHI:  keys_high_bits_next   = rx_byte[1:0];
      kfr_pkg::POS_ID:     captured_id_next      = rx_byte;
      kfr_pkg::POS_FIXED: begin
        if (rx_byte != kfr_pkg::FIXED_BYTE5) header_good_next = 1'b0;
      end
      kfr_pkg::POS_CRC_LO: crc_low_received_next = rx_byte;
      default: ;
    endcase

    if (byte_count < kfr_pkg::COUNT_MAX) begin
      byte_count_next = byte_count + {{(kfr_pkg::COUNT_W-1){1'b0}}, 1'b1};
    end else begin
      byte_count_next = byte_count;
    end

    rx_crc = {rx_byte, crc_low_received};

    if (byte_count_next != kfr_pkg::FRAME_BYTES) begin
      err = kfr_pkg::ERR_LENGTH;
    end else if (!header_good_next) begin
      err = kfr_pkg::ERR_HEADER;
    end else if (rx_crc != running_crc_next) begin
      err = kfr_pkg::ERR_CRC;
    end else begin
      err = kfr_pkg::ERR_NONE;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_frame)) begin
      byte_count       <= '0;
      running_crc      <= kfr_pkg::CRC_INIT;
      header_good      <= 1'b1;
      keys_low_byte    <= '0;
      keys_high_bits   <= '0;
      captured_id      <= '0;
      crc_low_received <= '0;
    end else if (accept) begin
      byte_count       <= byte_count_next;
      running_crc      <= running_crc_next;
      header_good      <= header_good_next;
      keys_low_byte    <= keys_low_byte_next;
      keys_high_bits   <= keys_high_bits_next;
      captured_id      <= captured_id_next;
      crc_low_received <= crc_low_received_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && end_of_frame) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && end_of_frame) begin
      frame_ok   <= (err == kfr_pkg::ERR_NONE);
      error_code <= err;
      if (err == kfr_pkg::ERR_NONE) begin
        pressed_keys <= {keys_high_bits_next, keys_low_byte_next};
        frame_number <= captured_id_next;
      end else begin
        pressed_keys <= '0;
        frame_number <= '0;
      end
    end
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for key_frame_receiver_crc16_top. Frames go in one
// byte per request. A byte-level predictor tracks the byte count, the
// CRC-16/MODBUS over bytes 0-5, the header and fixed-byte checks and the
// captured fields, and queues one expected result per end-of-frame byte.
// A monitor compares every result request with the oldest expectation.
// Directed frames come first, then random frames: well formed ones, ones
// with CRC, header or length faults, and pure noise. Both sides idle at
// random, and one long output hold-off backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef logic [7:0] frame_t[$];

  typedef struct packed {
    logic          ok;
    kfr_pkg::err_t err;
    logic [9:0]    mask;
    logic [7:0]    num;
  } frame_result_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int STIM_BYTES     = 950;
  localparam int HOLD_CYCLES    = 200;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;
  logic       out_valid;
  logic       out_ready;
  logic       frame_ok;
  logic [1:0] error_code;
  logic [9:0] pressed_keys;
  logic [7:0] frame_number;

  frame_result_t expected_q[$];
  int errors      = 0;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;

  // predictor state
  logic [3:0]  rx_count;
  logic [15:0] rx_crc;
  logic        hdr_ok;
  logic [7:0]  keys_lo;
  logic [1:0]  keys_hi;
  logic [7:0]  rx_id;
  logic [7:0]  crc_lo;

  key_frame_receiver_crc16_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_ok     (frame_ok),
    .error_code   (error_code),
    .pressed_keys (pressed_keys),
    .frame_number (frame_number)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // bitwise reflected crc, one byte
  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ 16'hA001) : (v >> 1);
    end
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_frame_state();
    rx_count = '0;
    rx_crc   = kfr_pkg::CRC_INIT;
    hdr_ok   = 1'b1;
    keys_lo  = '0;
    keys_hi  = '0;
    rx_id    = '0;
    crc_lo   = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eof);
    frame_result_t r;
    logic [15:0]   got_crc;
    if (rx_count < kfr_pkg::CRC_SPAN) rx_crc = crc_update(rx_crc, b);
    case (rx_count)
      kfr_pkg::POS_HDR0:   if (b != kfr_pkg::HDR_BYTE0) hdr_ok = 1'b0;
      kfr_pkg::POS_HDR1:   if (b != kfr_pkg::HDR_BYTE1) hdr_ok = 1'b0;
      kfr_pkg::POS_KEYLO:  keys_lo = b;
      kfr_pkg::POS_KEYHI:  keys_hi = b[1:0];
      kfr_pkg::POS_ID:     rx_id = b;
      kfr_pkg::POS_FIXED:  if (b != kfr_pkg::FIXED_BYTE5) hdr_ok = 1'b0;
      kfr_pkg::POS_CRC_LO: crc_lo = b;
      default: ;
    endcase
    if (rx_count < kfr_pkg::COUNT_MAX) rx_count = rx_count + 4'd1;
    if (eof) begin
      got_crc = {b, crc_lo};
      if (rx_count != kfr_pkg::FRAME_BYTES) r.err = kfr_pkg::ERR_LENGTH;
      else if (!hdr_ok) r.err = kfr_pkg::ERR_HEADER;
      else if (got_crc != rx_crc) r.err = kfr_pkg::ERR_CRC;
      else r.err = kfr_pkg::ERR_NONE;
      r.ok   = (r.err == kfr_pkg::ERR_NONE);
      r.mask = r.ok ? {keys_hi, keys_lo} : 10'd0;
      r.num  = r.ok ? rx_id : 8'd0;
      expected_q.push_back(r);
      clear_frame_state();
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    rx_byte      <= b;
    end_of_frame <= eof;
    do @(posedge clk); while (!in_ready);
    predict_byte(b, eof);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  function automatic frame_t good_frame(input logic [9:0] keys, input logic [7:0] id,
                                        input logic [5:0] spare);
    frame_t      f;
    logic [15:0] c;
    f = '{kfr_pkg::HDR_BYTE0, kfr_pkg::HDR_BYTE1, keys[7:0], {spare, keys[9:8]}, id,
          kfr_pkg::FIXED_BYTE5};
    c = kfr_pkg::CRC_INIT;
    foreach (f[i]) c = crc_update(c, f[i]);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    return f;
  endfunction

  function automatic frame_t random_good();
    return good_frame(10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                      6'($urandom_range(0, 63)));
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int     kind;
    int     n;
    int     p;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      n = $urandom_range(1, 12);
      repeat (n) f.push_back(8'($urandom_range(0, 255)));
      return f;
    end
    f = random_good();
    if (kind < 35) begin
      p = $urandom_range(6, 7);
      f[p] = f[p] ^ 8'($urandom_range(1, 255));
    end else if (kind < 50) begin
      case ($urandom_range(0, 2))
        0: p = kfr_pkg::POS_HDR0;
        1: p = kfr_pkg::POS_HDR1;
        default: p = kfr_pkg::POS_FIXED;
      endcase
      f[p] = f[p] ^ 8'($urandom_range(1, 255));
    end else if (kind < 62) begin
      n = $urandom_range(1, 11);
      if (n >= kfr_pkg::FRAME_BYTES) n++;
      while (f.size() > n) void'(f.pop_back());
      while (f.size() < n) f.push_back(8'($urandom_range(0, 255)));
    end
    return f;
  endfunction

  // tests

  task automatic test_field_extremes();
    send_frame(good_frame(10'h3FF, 8'hFF, 6'h3F));
    send_frame(good_frame(10'h000, 8'h00, 6'h00));
  endtask

  task automatic test_length_checks();
    frame_t f;
    // one-byte frame with a bad header still reports length
    f = '{8'h00};
    send_frame(f);
    // long frame, count saturates
    f = random_good();
    f.push_back(8'hFF);
    f.push_back(8'h00);
    send_frame(f);
  endtask

  task automatic test_header_and_crc();
    frame_t f;
    // bad fixed byte; the crc field no longer matches, but the header error wins
    f = random_good();
    f[kfr_pkg::POS_FIXED] = 8'hAA;
    send_frame(f);
    f = random_good();
    f[7] = f[7] ^ 8'h80;
    send_frame(f);
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (4) send_frame(random_good());
    quiet = 1'b0;
  endtask

  task automatic test_back_pressure();
    quiet    = 1'b1;
    hold_req = 1'b1;
    repeat (8) send_frame(random_frame());
    quiet = 1'b0;
  endtask

  task automatic test_random_frames();
    while (bytes_sent < STIM_BYTES) send_frame(random_frame());
  endtask

  // receiver side
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    frame_result_t r;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual ok=%0b err=%0d mask=%0h id=%0h",
                 $time, frame_ok, error_code, pressed_keys, frame_number);
      end else begin
        r = expected_q.pop_front();
        check_field("frame_ok", r.ok, frame_ok);
        check_field("error_code", r.err, error_code);
        check_field("pressed_keys", r.mask, pressed_keys);
        check_field("frame_number", r.num, frame_number);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("key_frame_receiver_crc16_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    rx_byte      = 8'h00;
    end_of_frame = 1'b0;
    clear_frame_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_field_extremes();
    test_length_checks();
    test_header_and_crc();
    test_back_to_back();
    test_back_pressure();
    test_random_frames();

    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("key_frame_receiver_crc16_top regression: pass");
    end else begin
      $display("key_frame_receiver_crc16_top regression: fail");
    end
    $finish;
  end

endmodule
